FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the failover selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/htfs_pkg.sv
// ----------------------------------------------------------------------------
// htfs_pkg
// Types and constants shared by the health threshold failover selector.
// ----------------------------------------------------------------------------
package htfs_pkg;

  localparam int ADDR_SLOT_W = 6;
  localparam int SVC_SLOT_W  = 3;
  localparam int HEALTH_W    = 2;
  localparam int TTL_W       = 32;
  localparam int ACOUNT_W    = 7;
  localparam int SCOUNT_W    = 4;
  localparam int THRESH_W    = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [HEALTH_W-1:0] HEALTH_UP   = 2'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESHOLD  = 2'd2;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_RESOLVE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [ADDR_SLOT_W-1:0] address_slot;
    logic [SVC_SLOT_W-1:0]  service_slot;
    logic [HEALTH_W-1:0]    health;
    logic [TTL_W-1:0]       ttl;
  } req_t;

  typedef struct packed {
    logic [ACOUNT_W-1:0] address_count;
    logic [SCOUNT_W-1:0] service_count;
    logic [THRESH_W-1:0] up_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UPD_READ,
    B_UPD_WRITE,
    B_COUNT,
    B_EMIT
  } back_state_t;

endpackage

FILE: rtl/core/health_threshold_failover_select.sv
// ----------------------------------------------------------------------------
// health_threshold_failover_select
// Health table with per-address, per-service states and threshold failover.
//
// A request is taken when start is high and busy is low; busy rises only
// when the two-entry request queue is full. An update request (kind 0) passes
// the back-end states idle (leaving the queue), read and write, and gives no
// result. A resolve request (kind 1) scans the table twice, one address row
// per cycle through the single read port of the health RAM: once to count
// usable addresses, once to emit them (only the usable ones if the threshold
// is met). Results come one per cycle at most on result_valid with their
// fields, in ascending address order, is_last on the final one; they are not
// held, so the receiver must take each in the cycle it is shown. The table
// reads as all up right after reset, with no clearing pass. Configuration is
// written through cfg_write/cfg_index/cfg_data while no request is pending.
// ----------------------------------------------------------------------------
module health_threshold_failover_select #(
  parameter int MAX_ADDRESSES = 64,
  parameter int MAX_SERVICES  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [htfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind,
  input  logic [htfs_pkg::ADDR_SLOT_W-1:0]     address_slot,
  input  logic [htfs_pkg::SVC_SLOT_W-1:0]      service_slot,
  input  logic [htfs_pkg::HEALTH_W-1:0]        health_value,
  input  logic [htfs_pkg::TTL_W-1:0]           ttl_in,
  output logic                                 result_valid,
  output logic [htfs_pkg::ADDR_SLOT_W-1:0]     chosen_address,
  output logic [htfs_pkg::TTL_W-1:0]           ttl_out,
  output logic                                 threshold_met,
  output logic                                 is_last
);
  import htfs_pkg::*;

  cfg_t cfg;
  logic q_valid;
  req_t q_head;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_count <= ACOUNT_W'(1);
      cfg.service_count <= SCOUNT_W'(1);
      cfg.up_threshold  <= THRESH_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ADDRESS_COUNT: cfg.address_count <= cfg_data[ACOUNT_W-1:0];
        CFG_SERVICE_COUNT: cfg.service_count <= cfg_data[SCOUNT_W-1:0];
        CFG_UP_THRESHOLD:  cfg.up_threshold  <= cfg_data[THRESH_W-1:0];
        default:           cfg <= cfg;
      endcase
    end
  end

  htfs_front #(
    .MAX_ADDRESSES (MAX_ADDRESSES),
    .MAX_SERVICES  (MAX_SERVICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .address_slot (address_slot),
    .service_slot (service_slot),
    .health_value (health_value),
    .ttl_in       (ttl_in),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  htfs_back #(
    .MAX_ADDRESSES (MAX_ADDRESSES),
    .MAX_SERVICES  (MAX_SERVICES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .chosen_address (chosen_address),
    .ttl_out        (ttl_out),
    .threshold_met  (threshold_met),
    .is_last        (is_last)
  );

endmodule

FILE: rtl/core/htfs_ram.sv
// ----------------------------------------------------------------------------
// htfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/htfs_front.sv
// ----------------------------------------------------------------------------
// htfs_front
// Takes requests, sorts them into updates and resolves, drops out-of-range
// updates and buffers the rest in a short queue for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htfs_front #(
  parameter int MAX_ADDRESSES = 64,
  parameter int MAX_SERVICES  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  kind,
  input  logic [htfs_pkg::ADDR_SLOT_W-1:0]      address_slot,
  input  logic [htfs_pkg::SVC_SLOT_W-1:0]       service_slot,
  input  logic [htfs_pkg::HEALTH_W-1:0]         health_value,
  input  logic [htfs_pkg::TTL_W-1:0]            ttl_in,
  output logic                                  q_valid,
  output htfs_pkg::req_t                        q_head,
  input  logic                                  q_pop
);
  import htfs_pkg::*;

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              accept;
  logic              in_range;
  logic              push;
  req_t              req;

  assign busy     = (count == QCNT_W'(QUEUE_DEPTH));
  assign accept   = start && !busy;
  assign in_range = (32'(address_slot) < MAX_ADDRESSES) &&
                    (32'(service_slot) < MAX_SERVICES);
  assign push     = accept && ((op_t'(kind) == OP_RESOLVE) || in_range);

  always_comb begin
    req.op           = op_t'(kind);
    req.address_slot = address_slot;
    req.service_slot = service_slot;
    // health code three is kept as down
    req.health       = (health_value > HEALTH_DOWN) ? HEALTH_DOWN : health_value;
    req.ttl          = ttl_in;
  end

  assign q_valid = (count != '0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, q_valid)
  `ASSERT_NEXT(a_push_grows, clk, rst, push && !q_pop, count == $past(count) + QCNT_W'(1))

endmodule

FILE: rtl/core/htfs_back.sv
// ----------------------------------------------------------------------------
// htfs_back
// Executes queued requests against the health table: read-modify-write of a
// table row for updates, and a two-pass scan (count, then emit) for resolves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htfs_back #(
  parameter int MAX_ADDRESSES = 64,
  parameter int MAX_SERVICES  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  htfs_pkg::cfg_t                     cfg,
  input  logic                               q_valid,
  input  htfs_pkg::req_t                     q_head,
  output logic                               q_pop,
  output logic                               result_valid,
  output logic [htfs_pkg::ADDR_SLOT_W-1:0]   chosen_address,
  output logic [htfs_pkg::TTL_W-1:0]         ttl_out,
  output logic                               threshold_met,
  output logic                               is_last
);
  import htfs_pkg::*;

  localparam int AIDX_W = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_ADDRESSES + 1);
  localparam int SCNT_W = $clog2(MAX_SERVICES + 1);
  localparam int ROW_W  = HEALTH_W * MAX_SERVICES;

  back_state_t        state;
  back_state_t        state_next;
  req_t               cur;
  logic [CNT_W-1:0]   issue_cnt;
  logic               rd_vld;
  logic [AIDX_W-1:0]  rd_idx;
  logic [MAX_ADDRESSES-1:0] row_valid;
  logic               row_valid_rd;
  logic [CNT_W-1:0]   good;
  logic               cut;
  logic [AIDX_W-1:0]  last_usable;
  logic               met;
  logic [TTL_W-1:0]   ttl_adj;

  logic [CNT_W-1:0]   n_lim;
  logic [SCNT_W-1:0]  svc_lim;
  logic [MAX_SERVICES-1:0] svc_mask;
  logic [MAX_SERVICES-1:0] down_bits;
  logic [MAX_SERVICES-1:0] danger_bits;
  logic [ROW_W-1:0]   rdata;
  logic [ROW_W-1:0]   row_data;
  logic [ROW_W-1:0]   wdata;
  logic               any_down;
  logic               not_up;
  logic               usable;
  logic               issue;
  logic               we;
  logic [AIDX_W-1:0]  mem_addr;
  logic               scan_done;
  logic               emit_now;
  logic               last_now;

  // effective counts, clamped to what the table holds
  always_comb begin
    if (32'(cfg.address_count) > MAX_ADDRESSES) begin
      n_lim = CNT_W'(MAX_ADDRESSES);
    end else begin
      n_lim = CNT_W'(cfg.address_count);
    end
    if (32'(cfg.service_count) > MAX_SERVICES) begin
      svc_lim = SCNT_W'(MAX_SERVICES);
    end else begin
      svc_lim = SCNT_W'(cfg.service_count);
    end
  end

  // rows never written read as all up
  assign row_data = row_valid_rd ? rdata : '0;

  // stored codes are 0..2 only, so bit 1 is down and bit 0 is danger
  always_comb begin
    for (int s = 0; s < MAX_SERVICES; s++) begin
      svc_mask[s]    = (32'(svc_lim) > s);
      down_bits[s]   = row_data[HEALTH_W*s + 1];
      danger_bits[s] = row_data[HEALTH_W*s];
    end
  end

  assign any_down = |(down_bits & svc_mask);
  assign not_up   = |((down_bits | danger_bits) & svc_mask);
  assign usable   = !any_down;

  always_comb begin
    wdata = row_data;
    for (int s = 0; s < MAX_SERVICES; s++) begin
      if (32'(cur.service_slot) == s) begin
        wdata[HEALTH_W*s +: HEALTH_W] = cur.health;
      end
    end
  end

  assign scan_done = (issue_cnt == n_lim) && !rd_vld;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (q_head.op == OP_RESOLVE) ? B_COUNT : B_UPD_READ;
        end
      end
      B_UPD_READ:  state_next = B_UPD_WRITE;
      B_UPD_WRITE: state_next = B_IDLE;
      B_COUNT: begin
        if (scan_done) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (scan_done) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    we       = 1'b0;
    issue    = 1'b0;
    mem_addr = AIDX_W'(cur.address_slot);
    case (state)
      B_IDLE:      q_pop = q_valid;
      B_UPD_READ:  mem_addr = AIDX_W'(cur.address_slot);
      B_UPD_WRITE: we = 1'b1;
      B_COUNT, B_EMIT: begin
        issue    = (issue_cnt < n_lim);
        mem_addr = issue_cnt[AIDX_W-1:0];
      end
      default: q_pop = 1'b0;
    endcase
  end

  htfs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ADDRESSES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (mem_addr),
    .wdata (wdata),
    .raddr (mem_addr),
    .rdata (rdata)
  );

  assign emit_now = (state == B_EMIT) && rd_vld && (!met || usable);
  assign last_now = met ? (rd_idx == last_usable)
                        : ((CNT_W'(rd_idx) + CNT_W'(1)) == n_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      rd_vld       <= 1'b0;
      issue_cnt    <= '0;
      row_valid    <= '0;
      result_valid <= 1'b0;
      good         <= '0;
      cut          <= 1'b0;
      met          <= 1'b0;
    end else begin
      state        <= state_next;
      rd_vld       <= issue;
      result_valid <= emit_now;
      if (we) begin
        row_valid[mem_addr] <= 1'b1;
      end
      if (state == B_IDLE || scan_done) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (state == B_IDLE) begin
        good <= '0;
        cut  <= 1'b0;
      end else if (state == B_COUNT && rd_vld) begin
        if (not_up) begin
          cut <= 1'b1;
        end
        if (usable) begin
          good <= good + CNT_W'(1);
        end
      end
      if (state == B_COUNT && scan_done) begin
        met <= !(32'(good) < 32'(cfg.up_threshold));
      end
    end
  end

  always_ff @(posedge clk) begin
    row_valid_rd <= row_valid[mem_addr];
    rd_idx       <= mem_addr;
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == B_COUNT && rd_vld && usable) begin
      last_usable <= rd_idx;
    end
    if (state == B_COUNT && scan_done) begin
      ttl_adj <= cut ? (cur.ttl >> 1) : cur.ttl;
    end
    if (emit_now) begin
      chosen_address <= ADDR_SLOT_W'(rd_idx);
      ttl_out        <= ttl_adj;
      threshold_met  <= met;
      is_last        <= last_now;
    end
  end

  `ASSERT_IMPL(a_write_in_update, clk, rst, we, state == B_UPD_WRITE)
  `ASSERT_IMPL(a_pop_when_idle, clk, rst, q_pop, state == B_IDLE)
  `ASSERT_IMPL(a_result_from_emit, clk, rst, result_valid, $past(state) == B_EMIT)
  `ASSERT_NEXT(a_last_ends_answer, clk, rst, result_valid && is_last, !result_valid)

endmodule
